@@ rtl/assert_macros.svh @@
// Assertion macros shared by the sampler RTL.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ rtl/hss_pkg.sv @@
// Shared types and constants for the HMM sequence sampler.
// No dependencies.
package hss_pkg;

    localparam int IDX_SPAN = 64;   // reach of the 6-bit state/column fields
    localparam int SYM_SPAN = 32;   // reach of the 5-bit symbol field
    localparam int CFG_DW   = 7;

    localparam logic [23:0] LEN_MAX = 24'hFF_FFFF;

    localparam logic [6:0] RST_NUM_STATES  = 7'd64;
    localparam logic [5:0] RST_NUM_SYMBOLS = 6'd32;
    localparam logic [5:0] RST_START_STATE = 6'd0;
    localparam logic [5:0] RST_END_STATE   = 6'd1;

    localparam logic [1:0] CFG_NUM_STATES  = 2'd0;
    localparam logic [1:0] CFG_NUM_SYMBOLS = 2'd1;
    localparam logic [1:0] CFG_START_STATE = 2'd2;
    localparam logic [1:0] CFG_END_STATE   = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD_TRANS = 2'd0,
        OP_LOAD_EMIT  = 2'd1,
        OP_STEP       = 2'd2,
        OP_RESTART    = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [5:0]  row_index;
        logic [5:0]  column_index;
        logic [32:0] threshold;
        logic [31:0] transition_draw;
        logic [31:0] emission_draw;
    } item_t;

    typedef struct packed {
        logic [4:0]  symbol;
        logic        symbol_valid;
        logic [5:0]  hidden_state;
        logic        sequence_done;
        logic [23:0] emitted_length;
    } result_t;

    // sequencer -> scan unit
    typedef struct packed {
        logic       start;
        logic [6:0] limit;
    } scan_ctl_t;

    // scan unit -> sequencer
    typedef struct packed {
        logic       done;
        logic       hit;
        logic [5:0] idx;
    } scan_sts_t;

endpackage

@@ rtl/hss_ram.sv @@
// Simple dual-port threshold RAM: one write port, one registered read port.
// No dependencies.
module hss_ram #(
    parameter int WIDTH = 33,
    parameter int AW    = 12
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/hss_scan.sv @@
// Shared threshold scan unit: walks one table row, one entry per cycle,
// and reports the first entry whose threshold is at or above the draw.
// Depends on hss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hss_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  hss_pkg::scan_ctl_t ctl,
    input  logic [31:0]       draw,
    input  logic [32:0]       thr,
    output logic [5:0]        rd_idx,
    output hss_pkg::scan_sts_t sts
);
    import hss_pkg::*;

    logic       busy_reg, busy_next;
    logic [6:0] iss_reg, iss_next;
    logic [6:0] lim_reg, lim_next;
    logic       cmp_vld_reg, cmp_vld_next;
    logic [5:0] cmp_idx_reg;
    logic       hit_now;
    logic       done;

    // thr is the registered read of the entry issued last cycle
    assign hit_now = busy_reg && cmp_vld_reg && ({1'b0, draw} <= thr);
    assign done    = busy_reg && (hit_now || (iss_reg >= lim_reg));
    assign rd_idx  = iss_reg[5:0];

    assign sts.done = done;
    assign sts.hit  = hit_now;
    assign sts.idx  = cmp_idx_reg;

    always_comb
    begin
        busy_next    = busy_reg;
        iss_next     = iss_reg;
        lim_next     = lim_reg;
        cmp_vld_next = cmp_vld_reg;
        if (ctl.start)
        begin
            busy_next    = 1'b1;
            iss_next     = '0;
            lim_next     = ctl.limit;
            cmp_vld_next = 1'b0;
        end
        else if (done)
        begin
            busy_next    = 1'b0;
            cmp_vld_next = 1'b0;
        end
        else if (busy_reg)
        begin
            cmp_vld_next = 1'b1;
            iss_next     = iss_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            iss_reg     <= '0;
            lim_reg     <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            iss_reg     <= iss_next;
            lim_reg     <= lim_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !done)
        begin
            cmp_idx_reg <= iss_reg[5:0];
        end
    end

    `ASSERT_PROP(a_hit_in_range, clk, rst_n, sts.done && sts.hit |-> 7'(sts.idx) < lim_reg)
    `ASSERT_PROP(a_issue_bounded, clk, rst_n, busy_reg |-> iss_reg <= lim_reg)
    `ASSERT_NEVER(a_restart_busy, clk, rst_n, ctl.start && busy_reg && !done)

endmodule

@@ rtl/hmm_sequence_sampler.sv @@
// HMM sequence sampler top: sequencer, config registers, tables, result register.
// Load and restart items: result register loaded at the accept edge.
// Step items: accept, transition row scan, emission row scan, S_POST, then the result
// register; no new item is accepted until S_IDLE is reached again. The scans compare
// entries up to the first hit (at most 64 + 32); one shared scan unit, one entry a cycle.
// Reset (async, active low): config 64/32/0/1, start state, zero length; tables uncleared.
`include "assert_macros.svh"

module hmm_sequence_sampler #(
    parameter int MAX_STATES  = 64,
    parameter int MAX_SYMBOLS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input items
    input  logic                         item_valid,
    output logic                         item_stall,
    input  hss_pkg::item_t               item,
    // result items
    output logic                         result_valid,
    input  logic                         result_stall,
    output hss_pkg::result_t             result,
    // configuration writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [hss_pkg::CFG_DW-1:0]   cfg_data
);
    import hss_pkg::*;

    // Table sizes: the index fields cap rows/columns at 64 states, 32 symbols.
    localparam int TS  = (MAX_STATES  < IDX_SPAN) ? MAX_STATES  : IDX_SPAN;
    localparam int ES  = (MAX_SYMBOLS < SYM_SPAN) ? MAX_SYMBOLS : SYM_SPAN;
    localparam int TW  = $clog2(TS);
    localparam int EW  = $clog2(ES);
    localparam logic [6:0] TS_L = 7'(TS);
    localparam logic [6:0] ES_L = 7'(ES);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_TSCAN = 4'b0010,   // transition row scan
        S_ESCAN = 4'b0100,   // emission row scan
        S_POST  = 4'b1000    // wait for the result register
    } state_t;

    state_t      state_reg, state_next;

    // configuration
    logic [6:0]  num_states_reg;
    logic [5:0]  num_symbols_reg;
    logic [5:0]  start_state_reg;
    logic [5:0]  end_state_reg;

    // sampler state
    logic [5:0]  cur_reg, cur_next;
    logic [23:0] len_reg, len_next;
    logic        pend_reg, pend_next;      // end reached, restart on next step
    logic [31:0] tdraw_reg, tdraw_next;
    logic [31:0] edraw_reg, edraw_next;
    logic [4:0]  sym_reg, sym_next;
    logic        symv_reg, symv_next;

    // result register
    logic        res_vld_reg, res_vld_next;
    result_t     res_reg, res_next;

    logic        take;
    logic        out_free;
    logic [5:0]  cur_step;
    logic [5:0]  row_new;
    logic [6:0]  st_lim;
    logic [6:0]  em_lim;
    logic        cur_at_end;

    scan_ctl_t   scn_ctl;
    scan_sts_t   scn_sts;
    logic [5:0]  rd_idx;
    logic [31:0] scan_draw;
    logic [32:0] scan_thr;

    logic           tr_we, em_we;
    logic [2*TW-1:0] tr_waddr, tr_raddr;
    logic [TW+EW-1:0] em_waddr, em_raddr;
    logic [32:0]    tr_rdata, em_rdata;

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign out_free     = !res_vld_reg || !result_stall;
    assign item_stall   = (state_reg != S_IDLE) || !out_free;
    assign take         = item_valid && !item_stall;
    assign result_valid = res_vld_reg;
    assign result       = res_reg;
    assign cfg_ready    = 1'b1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg  <= RST_NUM_STATES;
            num_symbols_reg <= RST_NUM_SYMBOLS;
            start_state_reg <= RST_START_STATE;
            end_state_reg   <= RST_END_STATE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NUM_STATES:  num_states_reg  <= cfg_data;
                CFG_NUM_SYMBOLS: num_symbols_reg <= cfg_data[5:0];
                CFG_START_STATE: start_state_reg <= cfg_data[5:0];
                CFG_END_STATE:   end_state_reg   <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Scan lengths: min of the register and the table size.
    assign st_lim = (num_states_reg < TS_L) ? num_states_reg : TS_L;
    assign em_lim = ({1'b0, num_symbols_reg} < ES_L) ? {1'b0, num_symbols_reg} : ES_L;

    // ---------------------------------------------------------------
    // Tables
    // ---------------------------------------------------------------
    assign tr_we = take && (item.op == OP_LOAD_TRANS)
                 && ({1'b0, item.row_index} < TS_L) && ({1'b0, item.column_index} < TS_L);
    assign em_we = take && (item.op == OP_LOAD_EMIT)
                 && ({1'b0, item.row_index} < TS_L) && ({1'b0, item.column_index} < ES_L);

    assign tr_waddr = {item.row_index[TW-1:0], item.column_index[TW-1:0]};
    assign em_waddr = {item.row_index[TW-1:0], item.column_index[EW-1:0]};
    // the row is the current state; the column comes from the scan unit
    assign tr_raddr = {cur_reg[TW-1:0], rd_idx[TW-1:0]};
    assign em_raddr = {cur_reg[TW-1:0], rd_idx[EW-1:0]};

    hss_ram #(
        .WIDTH (33),
        .AW    (2*TW)
    ) u_tr_ram (
        .clk   (clk),
        .we    (tr_we),
        .waddr (tr_waddr),
        .wdata (item.threshold),
        .raddr (tr_raddr),
        .rdata (tr_rdata)
    );

    hss_ram #(
        .WIDTH (33),
        .AW    (TW+EW)
    ) u_em_ram (
        .clk   (clk),
        .we    (em_we),
        .waddr (em_waddr),
        .wdata (item.threshold),
        .raddr (em_raddr),
        .rdata (em_rdata)
    );

    // ---------------------------------------------------------------
    // Shared scan unit
    // ---------------------------------------------------------------
    assign scan_thr  = (state_reg == S_ESCAN) ? em_rdata  : tr_rdata;
    assign scan_draw = (state_reg == S_ESCAN) ? edraw_reg : tdraw_reg;

    hss_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (scn_ctl),
        .draw   (scan_draw),
        .thr    (scan_thr),
        .rd_idx (rd_idx),
        .sts    (scn_sts)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign cur_step   = pend_reg ? start_state_reg : cur_reg;
    assign row_new    = scn_sts.hit ? scn_sts.idx : cur_reg;
    assign cur_at_end = (cur_reg == end_state_reg);

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        len_next     = len_reg;
        pend_next    = pend_reg;
        tdraw_next   = tdraw_reg;
        edraw_next   = edraw_reg;
        sym_next     = sym_reg;
        symv_next    = symv_reg;
        res_vld_next = res_vld_reg;
        res_next     = res_reg;
        scn_ctl      = '0;

        if (res_vld_reg && !result_stall)
        begin
            res_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (item.op)
                        OP_LOAD_TRANS, OP_LOAD_EMIT:
                        begin
                            res_next     = '{symbol: '0, symbol_valid: 1'b0,
                                             hidden_state: cur_reg, sequence_done: 1'b0,
                                             emitted_length: len_reg};
                            res_vld_next = 1'b1;
                        end
                        OP_RESTART:
                        begin
                            cur_next     = start_state_reg;
                            len_next     = '0;
                            pend_next    = 1'b0;
                            res_next     = '{symbol: '0, symbol_valid: 1'b0,
                                             hidden_state: start_state_reg,
                                             sequence_done: 1'b0, emitted_length: '0};
                            res_vld_next = 1'b1;
                        end
                        OP_STEP:
                        begin
                            // a pending end first drops back to the start state
                            cur_next      = cur_step;
                            len_next      = pend_reg ? 24'd0 : len_reg;
                            pend_next     = 1'b0;
                            tdraw_next    = item.transition_draw;
                            edraw_next    = item.emission_draw;
                            sym_next      = '0;
                            symv_next     = 1'b0;
                            scn_ctl.start = 1'b1;
                            scn_ctl.limit = ({1'b0, cur_step} < TS_L) ? st_lim : 7'd0;
                            state_next    = S_TSCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_TSCAN:
            begin
                if (scn_sts.done)
                begin
                    // no qualifying target keeps the state
                    cur_next      = row_new;
                    scn_ctl.start = 1'b1;
                    scn_ctl.limit = ({1'b0, row_new} < TS_L) ? em_lim : 7'd0;
                    state_next    = S_ESCAN;
                end
            end
            S_ESCAN:
            begin
                if (scn_sts.done)
                begin
                    if (scn_sts.hit)
                    begin
                        sym_next  = scn_sts.idx[4:0];
                        symv_next = 1'b1;
                        if (len_reg != LEN_MAX)
                        begin
                            len_next = len_reg + 24'd1;
                        end
                    end
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (out_free)
                begin
                    res_next     = '{symbol: sym_reg, symbol_valid: symv_reg,
                                     hidden_state: cur_reg, sequence_done: cur_at_end,
                                     emitted_length: len_reg};
                    res_vld_next = 1'b1;
                    pend_next    = cur_at_end;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cur_reg     <= RST_START_STATE;
            len_reg     <= '0;
            pend_reg    <= 1'b0;
            symv_reg    <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            len_reg     <= len_next;
            pend_reg    <= pend_next;
            symv_reg    <= symv_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tdraw_reg <= tdraw_next;
        edraw_reg <= edraw_next;
        sym_reg   <= sym_next;
        res_reg   <= res_next;
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `ASSERT_PROP(a_sym_zero, clk, rst_n, result_valid && !result.symbol_valid |-> result.symbol == 5'd0)
    `ASSERT_PROP(a_scan_owner, clk, rst_n, scn_sts.done |-> state_reg == S_TSCAN || state_reg == S_ESCAN)
    `ASSERT_PROP(a_emit_counts, clk, rst_n, state_reg == S_ESCAN && scn_sts.done && scn_sts.hit |=> len_reg != 24'd0)
    `ASSERT_PROP(a_step_clears_pend, clk, rst_n, take && item.op == OP_STEP |=> !pend_reg)

endmodule
